// ----- rtl/cna_pkg.sv -----
// shared types, opcode codes and helpers for the complex number alu
// no dependencies
package cna_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SQ_STAGES  = 32;

    localparam logic [2:0] OPC_ADD = 3'd0;
    localparam logic [2:0] OPC_SUB = 3'd1;
    localparam logic [2:0] OPC_SCR = 3'd2;
    localparam logic [2:0] OPC_SCI = 3'd3;
    localparam logic [2:0] OPC_MUL = 3'd4;
    localparam logic [2:0] OPC_MAG = 3'd5;

    typedef enum logic [2:0] {
        K_ADD = 3'd0,
        K_SUB = 3'd1,
        K_SCR = 3'd2,
        K_SCI = 3'd3,
        K_MUL = 3'd4,
        K_MAG = 3'd5,
        K_NOP = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
        logic signed [31:0] scalar;
    } t_item;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               ovf;
    } t_res;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } t_sat;

    function automatic t_kind classify(input logic [2:0] opc);
        t_kind k;
        case (opc)
            OPC_ADD: k = K_ADD;
            OPC_SUB: k = K_SUB;
            OPC_SCR: k = K_SCR;
            OPC_SCI: k = K_SCI;
            OPC_MUL: k = K_MUL;
            OPC_MAG: k = K_MAG;
            default: k = K_NOP;
        endcase
        return k;
    endfunction

    // clip a wide signed value to the 32-bit range
    function automatic t_sat sat32(input logic signed [66:0] v);
        t_sat s;
        if (v > 67'sh0_0000_0000_7FFF_FFFF) begin
            s.val = 32'sh7FFF_FFFF;
            s.ovf = 1'b1;
        end else if (v < -67'sh0_0000_0000_8000_0000) begin
            s.val = 32'sh8000_0000;
            s.ovf = 1'b1;
        end else begin
            s.val = v[31:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction

endpackage

// ----- rtl/complex_number_alu_core.sv -----
// top level of the fixed-point complex alu
// depends on cna_pkg, cna_front, cna_back, cna_sqrt
//
// usage
// - command channel: drive start with the opcode and operands; a transaction
//   is taken at a rising edge with start high and busy low
// - result channel: o_valid is high for exactly one cycle with
//   o_result_real, o_result_imag and o_overflow; the receiver cannot stall
// - one result per transaction, in order, opcodes 6 and 7 give zeros
// - throughput: one transaction per cycle, every cycle
// - path: every transaction passes the queue, 3 arithmetic stages, 32 square root stages
//   and 1 output register, whatever its opcode; the square root pipeline, one root bit
//   per stage, is the longest part of that path
// - every opcode travels the same pipeline so results never reorder
// - front queue holds two transactions; the back end drains it every cycle,
//   so busy stays low in normal use
// - reset (synchronous, active low) empties the queue and all valid bits;
//   payload registers are not cleared
module complex_number_alu_core #(
    parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_a_real,
    input  logic [31:0] i_a_imag,
    input  logic [31:0] i_b_real,
    input  logic [31:0] i_b_imag,
    input  logic [31:0] i_scalar,
    output logic        o_valid,
    output logic [31:0] o_result_real,
    output logic [31:0] o_result_imag,
    output logic        o_overflow
);
    import cna_pkg::*;

    logic  push;
    logic  q_vld;
    t_item q_item;
    logic  b_vld, b_mag;
    logic [63:0] b_rad;
    t_res  b_res;
    t_res  s_res;

    // accepted transaction
    assign push = start & ~busy;

    // front: classify and queue
    cna_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_opcode (i_opcode),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .i_scalar (i_scalar),
        .o_full   (busy),
        .o_vld    (q_vld),
        .o_item   (q_item)
    );

    // back: products, sums, rounding, saturation
    cna_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_item  (q_item),
        .o_vld   (b_vld),
        .o_mag   (b_mag),
        .o_rad   (b_rad),
        .o_res   (b_res)
    );

    // magnitude square root; other results pass alongside
    cna_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (b_vld),
        .i_mag   (b_mag),
        .i_rad   (b_rad),
        .i_res   (b_res),
        .o_vld   (o_valid),
        .o_res   (s_res)
    );

    assign o_result_real = s_res.re;
    assign o_result_imag = s_res.im;
    assign o_overflow    = s_res.ovf;

endmodule

// ----- rtl/cna_front.sv -----
// front end: accepts transactions, classifies the opcode, two-entry queue
// depends on cna_pkg
module cna_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [2:0]     i_opcode,
    input  logic [31:0]    i_a_real,
    input  logic [31:0]    i_a_imag,
    input  logic [31:0]    i_b_real,
    input  logic [31:0]    i_b_imag,
    input  logic [31:0]    i_scalar,
    output logic           o_full,
    output logic           o_vld,
    output cna_pkg::t_item o_item
);
    import cna_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;
    t_item      in_item;

    // back end never stalls, so the head leaves every cycle it is present
    assign pop    = (r_cnt != 2'd0);
    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = pop;
    assign o_item = r_q[r_rp];

    always_comb begin
        in_item.kind   = classify(i_opcode);
        in_item.a_real = i_a_real;
        in_item.a_imag = i_a_imag;
        in_item.b_real = i_b_real;
        in_item.b_imag = i_b_imag;
        in_item.scalar = i_scalar;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/cna_back.sv -----
// back end arithmetic: products, sums, rounding and saturation
// depends on cna_pkg
module cna_back #(
    parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  cna_pkg::t_item i_item,
    output logic           o_vld,
    output logic           o_mag,
    output logic [63:0]    o_rad,
    output cna_pkg::t_res  o_res
);
    import cna_pkg::*;

    localparam logic signed [66:0] HALF =
        (FRAC_BITS == 0) ? 67'sd0 : (67'sd1 <<< ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0));

    // stage a: multipliers and short sums
    logic               r_a_vld;
    t_kind              r_a_kind;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [32:0] r_a_sre, r_a_sim;
    logic signed [31:0] m0a, m0b, m1a, m1b, m2a, m2b, m3a, m3b;
    logic signed [32:0] n_sre, n_sim;

    // stage b: combined values
    logic               r_b_vld;
    t_kind              r_b_kind;
    logic signed [65:0] r_b_re, r_b_im;
    logic [63:0]        r_b_rad;
    logic signed [65:0] n_b_re, n_b_im;
    logic [63:0]        n_b_rad;

    // stage c: rounding and clipping
    logic signed [66:0] v_re, v_im, w_re, w_im;
    logic               rnd;
    t_sat               s_re, s_im;
    t_res               n_res;

    always_comb begin
        m0a = '0; m0b = '0; m1a = '0; m1b = '0;
        m2a = '0; m2b = '0; m3a = '0; m3b = '0;
        n_sre = '0; n_sim = '0;
        case (i_item.kind)
            K_ADD: begin
                n_sre = {i_item.a_real[31], i_item.a_real} + {i_item.b_real[31], i_item.b_real};
                n_sim = {i_item.a_imag[31], i_item.a_imag} + {i_item.b_imag[31], i_item.b_imag};
            end
            K_SUB: begin
                n_sre = {i_item.a_real[31], i_item.a_real} - {i_item.b_real[31], i_item.b_real};
                n_sim = {i_item.a_imag[31], i_item.a_imag} - {i_item.b_imag[31], i_item.b_imag};
            end
            K_SCR: begin
                m0a = i_item.a_real; m0b = i_item.scalar;
                m1a = i_item.a_imag; m1b = i_item.scalar;
            end
            K_SCI: begin
                m0a = i_item.a_imag; m0b = i_item.scalar;
                m1a = i_item.a_real; m1b = i_item.scalar;
            end
            K_MUL: begin
                m0a = i_item.a_real; m0b = i_item.b_real;
                m1a = i_item.a_imag; m1b = i_item.b_imag;
                m2a = i_item.a_real; m2b = i_item.b_imag;
                m3a = i_item.a_imag; m3b = i_item.b_real;
            end
            K_MAG: begin
                m0a = i_item.a_real; m0b = i_item.a_real;
                m1a = i_item.a_imag; m1b = i_item.a_imag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a_kind <= i_item.kind;
        r_p0     <= m0a * m0b;
        r_p1     <= m1a * m1b;
        r_p2     <= m2a * m2b;
        r_p3     <= m3a * m3b;
        r_a_sre  <= n_sre;
        r_a_sim  <= n_sim;
    end

    always_comb begin
        n_b_re  = '0;
        n_b_im  = '0;
        n_b_rad = '0;
        case (r_a_kind)
            K_ADD, K_SUB: begin
                n_b_re = {{33{r_a_sre[32]}}, r_a_sre};
                n_b_im = {{33{r_a_sim[32]}}, r_a_sim};
            end
            K_SCR: begin
                n_b_re = {{2{r_p0[63]}}, r_p0};
                n_b_im = {{2{r_p1[63]}}, r_p1};
            end
            K_SCI: begin
                n_b_re = -{{2{r_p0[63]}}, r_p0};
                n_b_im = {{2{r_p1[63]}}, r_p1};
            end
            K_MUL: begin
                n_b_re = {{2{r_p0[63]}}, r_p0} - {{2{r_p1[63]}}, r_p1};
                n_b_im = {{2{r_p2[63]}}, r_p2} + {{2{r_p3[63]}}, r_p3};
            end
            K_MAG: begin
                // both squares are non-negative and below 2^62 + 1
                n_b_rad = r_p0 + r_p1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_b_kind <= r_a_kind;
        r_b_re   <= n_b_re;
        r_b_im   <= n_b_im;
        r_b_rad  <= n_b_rad;
    end

    always_comb begin
        rnd  = (r_b_kind == K_SCR) || (r_b_kind == K_SCI) || (r_b_kind == K_MUL);
        v_re = {r_b_re[65], r_b_re};
        v_im = {r_b_im[65], r_b_im};
        if (rnd) begin
            w_re = (v_re + HALF) >>> FRAC_BITS;
            w_im = (v_im + HALF) >>> FRAC_BITS;
        end else begin
            w_re = v_re;
            w_im = v_im;
        end
        s_re = sat32(w_re);
        s_im = sat32(w_im);
        n_res.re  = s_re.val;
        n_res.im  = s_im.val;
        n_res.ovf = s_re.ovf | s_im.ovf;
        if ((r_b_kind == K_MAG) || (r_b_kind == K_NOP)) begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
        o_rad <= r_b_rad;
        o_mag <= (r_b_kind == K_MAG);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            o_vld   <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            o_vld   <= r_b_vld;
        end
    end

endmodule

// ----- rtl/cna_sqrt.sv -----
// pipelined restoring square root, one root bit per stage, with round to nearest
// depends on cna_pkg; other results ride along to keep order
module cna_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic          i_mag,
    input  logic [63:0]   i_rad,
    input  cna_pkg::t_res i_res,
    output logic          o_vld,
    output cna_pkg::t_res o_res
);
    import cna_pkg::*;

    logic [63:0] r_rad  [SQ_STAGES];
    logic [33:0] r_rem  [SQ_STAGES];
    logic [31:0] r_root [SQ_STAGES];
    t_res        r_pay  [SQ_STAGES];
    logic        r_mag  [SQ_STAGES];
    logic        r_vld  [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [63:0] rad_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        t_res        pay_in;
        logic        mag_in, vld_in;
        logic [35:0] cur, trial, diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign pay_in  = i_res;
            assign mag_in  = i_mag;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign pay_in  = r_pay[k-1];
            assign mag_in  = r_mag[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign cur   = {rem_in, rad_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= {rad_in[61:0], 2'b00};
            r_rem[k]  <= ge ? diff[33:0] : cur[33:0];
            r_root[k] <= {root_in[30:0], ge};
            r_pay[k]  <= pay_in;
            r_mag[k]  <= mag_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end
    end

    logic [32:0] rr;
    t_res        n_res;

    always_comb begin
        // round up when the remainder exceeds the root
        rr = {1'b0, r_root[SQ_STAGES-1]}
           + {32'd0, (r_rem[SQ_STAGES-1] > {2'b00, r_root[SQ_STAGES-1]})};
        n_res = r_pay[SQ_STAGES-1];
        if (r_mag[SQ_STAGES-1]) begin
            n_res.im = '0;
            if (rr > 33'h0_7FFF_FFFF) begin
                n_res.re  = 32'sh7FFF_FFFF;
                n_res.ovf = 1'b1;
            end else begin
                n_res.re  = rr[31:0];
                n_res.ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_vld[SQ_STAGES-1];
        end
    end

endmodule

// ----- tb/sv/complex_number_alu_core_tb.sv -----
// self-checking testbench for complex_number_alu_core: directed corner cases, then random
// transactions under several idle patterns, each result checked against a local predictor
// depends on cna_pkg and the rtl of complex_number_alu_core
module complex_number_alu_core_tb;
    import cna_pkg::*;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        ovf;
    } t_alu_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_opcode;
    logic [31:0] i_a_real, i_a_imag, i_b_real, i_b_imag, i_scalar;
    logic        o_valid;
    logic [31:0] o_result_real, o_result_imag;
    logic        o_overflow;

    // results still owed by the block, oldest first
    t_alu_result pending_results[$];
    int          error_count = 0;
    // percentage of cycles on which the sender stays idle
    int          idle_pct = 0;

    localparam int LATENCY = 37;
    localparam int FB      = FRAC_BITS_DEF;

    complex_number_alu_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_a_real      (i_a_real),
        .i_a_imag      (i_a_imag),
        .i_b_real      (i_b_real),
        .i_b_imag      (i_b_imag),
        .i_scalar      (i_scalar),
        .o_valid       (o_valid),
        .o_result_real (o_result_real),
        .o_result_imag (o_result_imag),
        .o_overflow    (o_overflow)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // clip a wide value to 32 bits, flag when clipped
    function automatic logic [31:0] clip32(input logic signed [67:0] v, inout logic ovf);
        if (v > 68'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -68'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // round a product sum with 2*FB fraction bits down to FB, half up, then clip;
    // the wide width covers the +2^63 multiply corner with no special path
    function automatic logic [31:0] round_clip(input logic signed [67:0] p, inout logic ovf);
        logic signed [67:0] r;
        r = (p + (68'sd1 <<< (FB - 1))) >>> FB;
        return clip32(r, ovf);
    endfunction

    // integer square root, rounded to nearest
    function automatic logic [63:0] round_sqrt(input logic [63:0] s);
        logic [63:0] r, b, x;
        r = 0;
        x = s;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic t_alu_result predict_alu(input logic [2:0] op,
            input logic signed [31:0] ar, input logic signed [31:0] ai,
            input logic signed [31:0] br, input logic signed [31:0] bi,
            input logic signed [31:0] sc);
        t_alu_result res;
        logic signed [67:0] ar_w, ai_w, br_w, bi_w, sc_w;
        logic [63:0] mag_sq, mag;
        ar_w = ar; ai_w = ai; br_w = br; bi_w = bi; sc_w = sc;
        res.re = '0;
        res.im = '0;
        res.ovf = 1'b0;
        case (op)
            OPC_ADD: begin
                res.re = clip32(ar_w + br_w, res.ovf);
                res.im = clip32(ai_w + bi_w, res.ovf);
            end
            OPC_SUB: begin
                res.re = clip32(ar_w - br_w, res.ovf);
                res.im = clip32(ai_w - bi_w, res.ovf);
            end
            OPC_SCR: begin
                res.re = round_clip(ar_w * sc_w, res.ovf);
                res.im = round_clip(ai_w * sc_w, res.ovf);
            end
            OPC_SCI: begin
                res.re = round_clip(-(ai_w * sc_w), res.ovf);
                res.im = round_clip(ar_w * sc_w, res.ovf);
            end
            OPC_MUL: begin
                res.re = round_clip(ar_w * br_w - ai_w * bi_w, res.ovf);
                res.im = round_clip(ar_w * bi_w + ai_w * br_w, res.ovf);
            end
            OPC_MAG: begin
                mag_sq = 64'((ar_w < 0 ? -ar_w : ar_w) * (ar_w < 0 ? -ar_w : ar_w))
                       + 64'((ai_w < 0 ? -ai_w : ai_w) * (ai_w < 0 ? -ai_w : ai_w));
                mag = round_sqrt(mag_sq);
                if (mag > 64'h7FFF_FFFF) begin
                    res.ovf = 1'b1;
                    res.re = 32'h7FFF_FFFF;
                end else begin
                    res.re = mag[31:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // drive one transaction at the falling edge and hold it until accepted;
    // start stays high afterwards so the next transaction can follow back to back
    task automatic send_op(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
            input logic [31:0] br, input logic [31:0] bi, input logic [31:0] sc);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_opcode <= op;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        i_scalar <= sc;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_alu(op, ar, ai, br, bi, sc));
        @(negedge i_clk);
    endtask

    // operand with a bias toward extremes and small Q16.16 values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // sender pauses until every outstanding result is back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        idle_pct = 0;
        // add and subtract, both saturation directions
        send_op(OPC_ADD, mx, mn, 32'd1, 32'hFFFF_FFFF, 0);
        send_op(OPC_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000, 0);
        send_op(OPC_SUB, mn, mx, 32'd1, 32'hFFFF_FFFF, 0);
        send_op(OPC_SUB, 0, 0, mn, mx, 0);
        // scaling, rounding ties and clipping
        send_op(OPC_SCR, 32'h0001_0000, 32'hFFFF_FFFF, 0, 0, 32'h0000_8000);
        send_op(OPC_SCR, mx, mn, 0, 0, mn);
        send_op(OPC_SCR, 32'd1, 32'hFFFF_FFFF, 0, 0, 32'h0000_8000);
        send_op(OPC_SCI, mx, mn, 0, 0, mx);
        send_op(OPC_SCI, 32'h0002_0000, 32'h0003_0000, 0, 0, 32'hFFFF_0000);
        // complex multiply, including the +2^63 corner
        send_op(OPC_MUL, mn, mn, mn, mx, 0);
        send_op(OPC_MUL, mn, mx, mn, mn, 0);
        send_op(OPC_MUL, mn, mn, mn, mn, 0);
        send_op(OPC_MUL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 0);
        // magnitude, in range and too large
        send_op(OPC_MAG, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0);
        send_op(OPC_MAG, mn, mn, mx, mx, mx);
        send_op(OPC_MAG, mx, 0, 0, 0, 0);
        send_op(OPC_MAG, 0, 0, 0, 0, 0);
        // undefined opcodes give zeros
        send_op(3'd6, mx, mn, mx, mn, mx);
        send_op(3'd7, mn, mx, mn, mx, mn);
        drain_results();
    endtask

    task automatic test_random(input int count, input int pct);
        logic [2:0] op;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            send_op(op, pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                    pick_operand());
        end
    endtask

    // result checker, one transaction per strobe
    always @(posedge i_clk) begin
        t_alu_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h ovf=%b", $time,
                         o_result_real, o_result_imag, o_overflow);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result_real !== exp_res.re) begin
                    $display("%0t: result_real expected %h actual %h", $time,
                             exp_res.re, o_result_real);
                    error_count++;
                end
                if (o_result_imag !== exp_res.im) begin
                    $display("%0t: result_imag expected %h actual %h", $time,
                             exp_res.im, o_result_imag);
                    error_count++;
                end
                if (o_overflow !== exp_res.ovf) begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             exp_res.ovf, o_overflow);
                    error_count++;
                end
            end
        end
    end

    // watchdog well beyond the slowest run
    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int wait_cycles;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_opcode = '0;
        i_a_real = '0;
        i_a_imag = '0;
        i_b_real = '0;
        i_b_imag = '0;
        i_scalar = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(300, 0);
        test_random(250, 52);
        drain_results();
        test_random(250, 0);
        test_random(250, 16);

        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 10 * LATENCY) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 4) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
